// ===== design/arm64dp_pkg.sv =====
// Shared types and constants for the AArch64 data-processing execute unit.
`default_nettype none

package arm64dp_pkg;

  localparam int XLEN      = 64;
  localparam int NUM_REGS  = 31;
  localparam int REG_IDX_W = 5;
  localparam int NUM_SRC   = 3;

  localparam int SRC_RN = 0;
  localparam int SRC_RM = 1;
  localparam int SRC_RA = 2;

  localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'b11111;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] SH_LSL = 2'b00;
  localparam logic [1:0] SH_LSR = 2'b01;
  localparam logic [1:0] SH_ASR = 2'b10;
  localparam logic [1:0] SH_ROR = 2'b11;

  localparam logic [1:0] LG_AND  = 2'b00;
  localparam logic [1:0] LG_ORR  = 2'b01;
  localparam logic [1:0] LG_EOR  = 2'b10;
  localparam logic [1:0] LG_ANDS = 2'b11;

  typedef struct packed {
    logic            operation;
    logic [31:0]     instruction;
    logic [4:0]      reg_index;
    logic [XLEN-1:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]      dest_index;
    logic            write_done;
    logic [XLEN-1:0] result_value;
    logic            flag_n;
    logic            flag_z;
    logic            flag_c;
    logic            flag_v;
  } out_item_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] rn;
    logic [REG_IDX_W-1:0] rm;
    logic [REG_IDX_W-1:0] ra;
  } rf_rd_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

endpackage

`default_nettype wire

// ===== design/arm64dp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arm64dp_ram #(
  parameter int DEPTH = 31,
  parameter int WIDTH = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/arm64dp_regfile.sv =====
// General register file: one RAM copy per source operand, valid bits and write bypass.
`default_nettype none

module arm64dp_regfile (
  input  logic                     clk,
  input  logic                     rst,
  input  arm64dp_pkg::rf_rd_t      rd,
  input  arm64dp_pkg::rf_wr_t      wr,
  output logic [arm64dp_pkg::XLEN-1:0] rn_val,
  output logic [arm64dp_pkg::XLEN-1:0] rm_val,
  output logic [arm64dp_pkg::XLEN-1:0] ra_val
);

  import arm64dp_pkg::*;

  logic [NUM_SRC-1:0][REG_IDX_W-1:0] addr;
  logic [NUM_SRC-1:0][REG_IDX_W-1:0] addr_q;
  logic [NUM_SRC-1:0]                ok_q;
  logic [NUM_SRC-1:0][XLEN-1:0]      rdata;
  logic [NUM_SRC-1:0][XLEN-1:0]      opnd;
  logic [NUM_REGS-1:0]               vld;
  logic                              lw_en;
  logic [REG_IDX_W-1:0]              lw_idx;
  logic [XLEN-1:0]                   lw_data;

  assign addr[SRC_RN] = rd.rn;
  assign addr[SRC_RM] = rd.rm;
  assign addr[SRC_RA] = rd.ra;

  // An entry never written reads as zero, and so does the zero register.
  for (genvar p = 0; p < NUM_SRC; p++) begin : g_port
    arm64dp_ram #(
      .DEPTH(NUM_REGS),
      .WIDTH(XLEN)
    ) u_ram (
      .clk  (clk),
      .we   (wr.en),
      .waddr(wr.idx),
      .wdata(wr.data),
      .re   (rd.en),
      .raddr(addr[p]),
      .rdata(rdata[p])
    );

    always_ff @(posedge clk) begin
      if (rd.en) begin
        addr_q[p] <= addr[p];
        ok_q[p]   <= (addr[p] != ZERO_REG) && vld[addr[p]];
      end
    end

    // The write made on the same edge as the read is missing from the RAM data.
    assign opnd[p] = (lw_en && (lw_idx == addr_q[p])) ? lw_data :
                     (ok_q[p] ? rdata[p] : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      lw_en <= 1'b0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
      lw_en       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lw_idx  <= wr.idx;
      lw_data <= wr.data;
    end
  end

  assign rn_val = opnd[SRC_RN];
  assign rm_val = opnd[SRC_RM];
  assign ra_val = opnd[SRC_RA];

endmodule

`default_nettype wire

// ===== design/arm64dp_alu.sv =====
// Execute logic: shifter, adder, logic unit, multiply-accumulate and flag update.
`default_nettype none

module arm64dp_alu (
  input  arm64dp_pkg::in_item_t            item,
  input  logic [arm64dp_pkg::XLEN-1:0]     rn_val,
  input  logic [arm64dp_pkg::XLEN-1:0]     rm_val,
  input  logic [arm64dp_pkg::XLEN-1:0]     ra_val,
  input  arm64dp_pkg::flags_t              flags,
  output arm64dp_pkg::out_item_t           res
);

  import arm64dp_pkg::*;

  logic [31:0]     ins;
  logic            wide;
  logic [XLEN-1:0] mask;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] bm;
  logic [XLEN-1:0] acc;
  logic [5:0]      amt;
  logic [XLEN-1:0] b64;
  logic [31:0]     b32;
  logic [XLEN-1:0] sh;
  logic            sub;
  logic [XLEN-1:0] bb;
  logic [XLEN:0]   sum65;
  logic [32:0]     sum32;
  logic [XLEN-1:0] ar_res;
  logic            carry;
  logic [XLEN-1:0] ovf_vec;
  logic [XLEN-1:0] lb;
  logic [XLEN-1:0] lg_res;
  logic [63:0]     pp_ll;
  logic [31:0]     pp_lh;
  logic [31:0]     pp_hl;
  logic [XLEN-1:0] prod;
  logic [XLEN-1:0] mul_res;
  logic [4:0]      dest;
  logic [XLEN-1:0] value;
  flags_t          nf;

  assign ins  = item.instruction;
  assign wide = ins[31];
  assign mask = wide ? {XLEN{1'b1}} : {32'b0, 32'hFFFF_FFFF};
  assign a    = rn_val & mask;
  assign bm   = rm_val & mask;
  assign acc  = ra_val & mask;
  assign amt  = wide ? ins[15:10] : {1'b0, ins[14:10]};

  always_comb begin
    case (ins[23:22])
      SH_LSL: begin
        b64 = bm << amt;
        b32 = bm[31:0] << amt[4:0];
      end
      SH_LSR: begin
        b64 = bm >> amt;
        b32 = bm[31:0] >> amt[4:0];
      end
      SH_ASR: begin
        b64 = XLEN'($signed(bm) >>> amt);
        b32 = 32'($signed(bm[31:0]) >>> amt[4:0]);
      end
      default: begin
        b64 = (bm >> amt) | (bm << (7'd64 - {1'b0, amt}));
        b32 = (bm[31:0] >> amt[4:0]) | (bm[31:0] << (6'd32 - {1'b0, amt[4:0]}));
      end
    endcase
  end

  assign sh = wide ? b64 : {32'b0, b32};

  assign sub     = ins[30];
  assign bb      = sub ? (~sh & mask) : sh;
  assign sum65   = {1'b0, a} + {1'b0, bb} + {{XLEN{1'b0}}, sub};
  assign sum32   = {1'b0, a[31:0]} + {1'b0, bb[31:0]} + {32'b0, sub};
  assign ar_res  = wide ? sum65[XLEN-1:0] : {32'b0, sum32[31:0]};
  assign carry   = wide ? sum65[XLEN] : sum32[32];
  assign ovf_vec = (a ^ ar_res) & (bb ^ ar_res);

  assign lb = ins[21] ? (~sh & mask) : sh;

  always_comb begin
    case (ins[30:29])
      LG_ORR:  lg_res = (a | lb) & mask;
      LG_EOR:  lg_res = (a ^ lb) & mask;
      default: lg_res = (a & lb) & mask;
    endcase
  end

  // Only the low 64 bits of the product matter, so three 32x32 partial products suffice.
  assign pp_ll   = a[31:0] * bm[31:0];
  assign pp_lh   = a[31:0] * bm[63:32];
  assign pp_hl   = a[63:32] * bm[31:0];
  assign prod    = pp_ll + {pp_lh + pp_hl, 32'b0};
  assign mul_res = (ins[15] ? (acc - prod) : (acc + prod)) & mask;

  always_comb begin
    nf    = flags;
    dest  = ins[4:0];
    value = lg_res;
    if (item.operation == OP_LOAD) begin
      dest  = item.reg_index;
      value = item.reg_value;
    end else if (ins[28]) begin
      value = mul_res;
    end else if (ins[24] && !ins[21]) begin
      value = ar_res;
      if (ins[29]) begin
        nf.n = wide ? ar_res[63] : ar_res[31];
        nf.z = (ar_res == '0);
        nf.c = carry;
        nf.v = wide ? ovf_vec[63] : ovf_vec[31];
      end
    end else if (ins[30:29] == LG_ANDS) begin
      nf.n = wide ? lg_res[63] : lg_res[31];
      nf.z = (lg_res == '0);
      nf.c = 1'b0;
      nf.v = 1'b0;
    end
  end

  assign res.dest_index   = dest;
  assign res.write_done   = (dest != ZERO_REG);
  assign res.result_value = value;
  assign res.flag_n       = nf.n;
  assign res.flag_z       = nf.z;
  assign res.flag_c       = nf.c;
  assign res.flag_v       = nf.v;

endmodule

`default_nettype wire

// ===== design/arm64_register_dp_execute_unit.sv =====
// Top level of the AArch64 data-processing (register) execute unit.
//
//   Channel   Direction  Handshake               Beat
//   item      in         item_valid/item_stall   in_item_t
//   result    out        result_valid/result_stall out_item_t
//
// The result of a beat is registered when it leaves execute: the register
// file is read on the accepting edge and execute runs in the cycle that follows.
// A new beat can be accepted every cycle while item_stall is low.
// Dependent beats are served by a bypass of the last register write.
// Reset clears the flags and the register valid bits, so all registers read as zero.
// item_stall rises only while a finished result is held by result_stall
// and another beat waits behind it.
`default_nettype none

module arm64_register_dp_execute_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  arm64dp_pkg::in_item_t  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output arm64dp_pkg::out_item_t result
);

  import arm64dp_pkg::*;

  logic            accept;
  logic            ex_valid;
  in_item_t        ex_item;
  logic            ex_adv;
  flags_t          flags;
  rf_rd_t          rd;
  rf_wr_t          wr;
  logic [XLEN-1:0] rn_val;
  logic [XLEN-1:0] rm_val;
  logic [XLEN-1:0] ra_val;
  out_item_t       alu_res;

  assign ex_adv     = ex_valid && (!result_valid || !result_stall);
  assign item_stall = ex_valid && !ex_adv;
  assign accept     = item_valid && !item_stall;

  assign rd.en = accept;
  assign rd.rn = item.instruction[9:5];
  assign rd.rm = item.instruction[20:16];
  assign rd.ra = item.instruction[14:10];

  assign wr.en   = ex_adv && alu_res.write_done;
  assign wr.idx  = alu_res.dest_index;
  assign wr.data = alu_res.result_value;

  arm64dp_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .rn_val(rn_val),
    .rm_val(rm_val),
    .ra_val(ra_val)
  );

  arm64dp_alu u_alu (
    .item  (ex_item),
    .rn_val(rn_val),
    .rm_val(rm_val),
    .ra_val(ra_val),
    .flags (flags),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid     <= 1'b0;
      result_valid <= 1'b0;
      flags        <= '0;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (ex_adv) begin
        ex_valid <= 1'b0;
      end
      if (ex_adv) begin
        result_valid <= 1'b1;
        flags        <= {alu_res.flag_n, alu_res.flag_z, alu_res.flag_c, alu_res.flag_v};
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= item;
    end
    if (ex_adv) begin
      result <= alu_res;
    end
  end

endmodule

`default_nettype wire

// ===== design/arm64dp_checker.sv =====
// Port-level checks for the execute unit, bound to its top level.
`default_nettype none

module arm64dp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input arm64dp_pkg::in_item_t  item,
  input logic                   result_valid,
  input logic                   result_stall,
  input arm64dp_pkg::out_item_t result
);

  import arm64dp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result beat changed or dropped.");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("Stalled input beat changed or dropped.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("Input stalled while the result side was free.");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result valid right after reset.");

  a_zero_dest: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_done |-> result.dest_index != ZERO_REG)
    else $error("Write reported for the zero register.");

endmodule

bind arm64_register_dp_execute_unit arm64dp_checker u_checker (.*);

`default_nettype wire
